/* hdl/pcw_pkg.sv */
`timescale 1ns / 1ps

package pcw_pkg;

  // Request kinds carried in the func field.
  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_SEARCH = 2'd2
  } pcw_func_t;

  // Fixed places and codes of the configuration header.
  localparam logic [8:0] STATUS_OFS     = 9'h006;
  localparam logic [8:0] HDRTYPE_OFS    = 9'h00e;
  localparam logic [7:0] CAP_PTR_STD    = 8'h34;
  localparam logic [7:0] CAP_PTR_CB     = 8'h14;
  localparam logic [7:0] CAP_MIN        = 8'h40;
  localparam logic [7:0] CAP_ID_END     = 8'hff;
  localparam logic [7:0] CAP_ALIGN_MASK = 8'hfc;
  localparam logic [6:0] HDR_TYPE_MASK  = 7'h7f;
  localparam logic [6:0] HDR_DEVICE     = 7'd0;
  localparam logic [6:0] HDR_BRIDGE     = 7'd1;
  localparam logic [6:0] HDR_CARDBUS    = 7'd2;
  localparam int         STATUS_CAP_BIT = 4;

  // Address source of a store read.
  typedef enum logic [2:0] {
    RD_OFS,
    RD_STATUS,
    RD_HDR,
    RD_PTR,
    RD_CAP
  } pcw_rd_sel_t;

  // Source of the next-pointer register.
  typedef enum logic [1:0] {
    PTR_START,
    PTR_STD,
    PTR_CB,
    PTR_CAP
  } pcw_ptr_sel_t;

  // How the result registers are loaded.
  typedef enum logic [1:0] {
    RES_NONE,
    RES_ERR,
    RES_READ,
    RES_FOUND
  } pcw_res_t;

  typedef struct packed {
    logic         load_req;
    logic         clr_en;
    logic         wr_en;
    logic         rd_en;
    pcw_rd_sel_t  rd_sel;
    logic         ptr_load;
    pcw_ptr_sel_t ptr_sel;
    logic         cap_load;
    logic         hop_clr;
    logic         hop_inc;
    logic         res_set;
    pcw_res_t     res_kind;
    logic         out_load;
  } pcw_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       acc_ok;
    logic       clr_last;
    logic       cap_enabled;
    logic       start_zero;
    logic       hdr_std;
    logic       hdr_cb;
    logic       ptr_in_range;
    logic       ptr_low;
    logic       cap_in_range;
    logic       id_end;
    logic       id_match;
    logic       hops_last;
    logic       out_free;
  } pcw_sts_t;

endpackage

/* hdl/pcw_if.sv */
`timescale 1ns / 1ps

interface pcw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  offset;
  logic [2:0]  access_size;
  logic [31:0] write_data;
  logic [7:0]  start_offset;
  logic [7:0]  cap_id;
  logic        match_any;

  modport source (
    output valid, func, offset, access_size, write_data, start_offset, cap_id, match_any,
    input  ready
  );
  modport sink (
    input  valid, func, offset, access_size, write_data, start_offset, cap_id, match_any,
    output ready
  );
endinterface

interface pcw_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        access_error;
  logic        cap_found;
  logic [7:0]  cap_offset;

  modport source (
    output valid, read_data, access_error, cap_found, cap_offset,
    input  ready
  );
  modport sink (
    input  valid, read_data, access_error, cap_found, cap_offset,
    output ready
  );
endinterface

/* hdl/pcw_ctrl.sv */
`timescale 1ns / 1ps

module pcw_ctrl
  import pcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pcw_sts_t sts,
  output pcw_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_RD_DATA,
    S_STAT,
    S_HDR,
    S_PTR,
    S_PTR_CHK,
    S_ID_CHK,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_OFS;
    cmd.ptr_sel = PTR_START;
    cmd.res_kind = RES_NONE;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        case (sts.func)
          FUNC_READ: begin
            if (sts.acc_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_OFS;
              state_next = S_RD_DATA;
            end else begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = RES_ERR;
            end
          end
          FUNC_WRITE: begin
            cmd.wr_en    = sts.acc_ok;
            cmd.res_set  = 1'b1;
            cmd.res_kind = sts.acc_ok ? RES_NONE : RES_ERR;
          end
          FUNC_SEARCH: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_STATUS;
            cmd.hop_clr = 1'b1;
            state_next  = S_STAT;
          end
          default: begin
            cmd.res_set  = 1'b1;
            cmd.res_kind = RES_ERR;
          end
        endcase
      end
      S_RD_DATA: begin
        cmd.res_set  = 1'b1;
        cmd.res_kind = RES_READ;
        state_next   = S_DONE;
      end
      S_STAT: begin
        if (!sts.cap_enabled) begin
          cmd.res_set = 1'b1;
          state_next  = S_DONE;
        end else if (sts.start_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HDR;
          state_next = S_HDR;
        end else begin
          cmd.ptr_load = 1'b1;
          cmd.ptr_sel  = PTR_START;
          state_next   = S_PTR;
        end
      end
      S_HDR: begin
        if (sts.hdr_std || sts.hdr_cb) begin
          cmd.ptr_load = 1'b1;
          cmd.ptr_sel  = sts.hdr_std ? PTR_STD : PTR_CB;
          state_next   = S_PTR;
        end else begin
          cmd.res_set = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_PTR: begin
        if (sts.ptr_in_range) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_next = S_PTR_CHK;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_ERR;
          state_next   = S_DONE;
        end
      end
      S_PTR_CHK: begin
        if (sts.ptr_low) begin
          cmd.res_set = 1'b1;
          state_next  = S_DONE;
        end else if (!sts.cap_in_range) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_ERR;
          state_next   = S_DONE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_CAP;
          cmd.cap_load = 1'b1;
          state_next   = S_ID_CHK;
        end
      end
      S_ID_CHK: begin
        if (sts.id_end) begin
          cmd.res_set = 1'b1;
          state_next  = S_DONE;
        end else if (sts.id_match) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_FOUND;
          state_next   = S_DONE;
        end else if (sts.hops_last) begin
          cmd.res_set = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.hop_inc  = 1'b1;
          cmd.ptr_load = 1'b1;
          cmd.ptr_sel  = PTR_CAP;
          state_next   = S_PTR;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/pcw_dp.sv */
`timescale 1ns / 1ps

module pcw_dp
  import pcw_pkg::*;
#(
  parameter int CFG_BYTES = 256,
  parameter int MAX_HOPS  = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  pcw_cmd_t    cmd,
  output pcw_sts_t    sts,
  input  logic [1:0]  func,
  input  logic [7:0]  offset,
  input  logic [2:0]  access_size,
  input  logic [31:0] write_data,
  input  logic [7:0]  start_offset,
  input  logic [7:0]  cap_id,
  input  logic        match_any,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        access_error,
  output logic        cap_found,
  output logic [7:0]  cap_offset
);

  localparam int WORDS = (CFG_BYTES + 3) / 4;
  localparam int AW    = $clog2(WORDS);
  localparam int HW    = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

  // Store: one dword per row, byte lanes written under enables.
  logic [31:0] mem [WORDS];
  logic [31:0] rdata;
  logic [1:0]  rd_lane;
  logic [AW-1:0] clr_addr;

  // Latched request.
  logic [1:0]  r_func;
  logic [7:0]  r_ofs;
  logic [2:0]  r_size;
  logic [31:0] r_wdata;
  logic [7:0]  r_start;
  logic [7:0]  r_id;
  logic        r_any;

  // Walk registers.
  logic [8:0]    ptr;
  logic [7:0]    cap;
  logic [HW-1:0] hop;

  // Result and output registers.
  logic [31:0] res_data;
  logic        res_err;
  logic        res_found;
  logic [7:0]  res_where;

  logic [7:0]  sel_byte;
  logic [7:0]  cap_now;
  logic [8:0]  rd_idx;
  logic [8:0]  acc_end;
  logic        size_ok;
  logic        align_ok;
  logic [31:0] rd_shift;
  logic [31:0] rd_value;
  logic [31:0] wdata_sh;
  logic [3:0]  be;
  logic [AW-1:0] waddr;
  logic [6:0]  hdr_type;

  assign sel_byte = rdata[{rd_lane, 3'b000} +: 8];
  assign cap_now  = sel_byte & CAP_ALIGN_MASK;
  assign hdr_type = sel_byte[6:0] & HDR_TYPE_MASK;

  always_comb begin
    case (cmd.rd_sel)
      RD_OFS:    rd_idx = {1'b0, r_ofs};
      RD_STATUS: rd_idx = STATUS_OFS;
      RD_HDR:    rd_idx = HDRTYPE_OFS;
      RD_PTR:    rd_idx = ptr;
      RD_CAP:    rd_idx = {1'b0, cap_now};
      default:   rd_idx = {1'b0, r_ofs};
    endcase
  end

  // Access checks for reads and writes.
  assign acc_end = {1'b0, r_ofs} + {6'd0, r_size};
  always_comb begin
    case (r_size)
      3'd1: begin
        size_ok  = 1'b1;
        align_ok = 1'b1;
      end
      3'd2: begin
        size_ok  = 1'b1;
        align_ok = (r_ofs[0] == 1'b0);
      end
      3'd4: begin
        size_ok  = 1'b1;
        align_ok = (r_ofs[1:0] == 2'd0);
      end
      default: begin
        size_ok  = 1'b0;
        align_ok = 1'b0;
      end
    endcase
  end

  assign rd_shift = rdata >> {r_ofs[1:0], 3'b000};
  always_comb begin
    case (r_size)
      3'd1:    rd_value = {24'd0, rd_shift[7:0]};
      3'd2:    rd_value = {16'd0, rd_shift[15:0]};
      default: rd_value = rd_shift;
    endcase
  end

  assign wdata_sh = r_wdata << {r_ofs[1:0], 3'b000};
  always_comb begin
    case (r_size)
      3'd1:    be = 4'b0001 << r_ofs[1:0];
      3'd2:    be = 4'b0011 << r_ofs[1:0];
      default: be = 4'b1111;
    endcase
  end
  assign waddr = AW'(r_ofs[7:2]);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr_en) begin
      for (int l = 0; l < 4; l++) begin
        if (be[l]) mem[waddr][8*l +: 8] <= wdata_sh[8*l +: 8];
      end
    end
    if (cmd.rd_en) begin
      rdata   <= mem[AW'(rd_idx[8:2])];
      rd_lane <= rd_idx[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r_func  <= func;
      r_ofs   <= offset;
      r_size  <= access_size;
      r_wdata <= write_data;
      r_start <= start_offset;
      r_id    <= cap_id;
      r_any   <= match_any;
    end
    if (cmd.ptr_load) begin
      case (cmd.ptr_sel)
        PTR_START: ptr <= {1'b0, r_start} + 9'd1;
        PTR_STD:   ptr <= {1'b0, CAP_PTR_STD};
        PTR_CB:    ptr <= {1'b0, CAP_PTR_CB};
        PTR_CAP:   ptr <= {1'b0, cap} + 9'd1;
        default:   ptr <= {1'b0, CAP_PTR_STD};
      endcase
    end
    if (cmd.cap_load) cap <= cap_now;
    if (cmd.hop_clr) begin
      hop <= '0;
    end else if (cmd.hop_inc) begin
      hop <= hop + HW'(1);
    end
    if (cmd.res_set) begin
      res_data  <= '0;
      res_err   <= 1'b0;
      res_found <= 1'b0;
      res_where <= '0;
      case (cmd.res_kind)
        RES_ERR:   res_err <= 1'b1;
        RES_READ:  res_data <= rd_value;
        RES_FOUND: begin
          res_found <= 1'b1;
          res_where <= cap;
        end
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      read_data    <= res_data;
      access_error <= res_err;
      cap_found    <= res_found;
      cap_offset   <= res_where;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The status and header-type bytes lie below 64, so they are always in range.
  always_comb begin
    sts.func         = r_func;
    sts.acc_ok       = size_ok && align_ok && ({23'd0, acc_end} <= 32'(CFG_BYTES));
    sts.clr_last     = (clr_addr == AW'(WORDS - 1));
    sts.cap_enabled  = sel_byte[STATUS_CAP_BIT];
    sts.start_zero   = (r_start == 8'd0);
    sts.hdr_std      = (hdr_type == HDR_DEVICE) || (hdr_type == HDR_BRIDGE);
    sts.hdr_cb       = (hdr_type == HDR_CARDBUS);
    sts.ptr_in_range = ({23'd0, ptr} < 32'(CFG_BYTES));
    sts.ptr_low      = (sel_byte < CAP_MIN);
    sts.cap_in_range = ({24'd0, cap_now} < 32'(CFG_BYTES));
    sts.id_end       = (sel_byte == CAP_ID_END);
    sts.id_match     = r_any || (sel_byte == r_id);
    sts.hops_last    = (hop == HW'(MAX_HOPS - 1));
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

/* hdl/pci_config_space_cap_walker_core.sv */
`timescale 1ns / 1ps

// PCI configuration space with a capability list walker.
// Requests arrive on the req channel (valid/ready); each request transfer
// yields exactly one response transfer on the rsp channel, in order.
// func 0 reads 1, 2 or 4 aligned little-endian bytes, func 1 writes them,
// func 2 walks the capability list for cap_id (or any ID with match_any).
// Bad size, misalignment, an access past the store or func 3 answer with
// access_error set; nothing in the store changes then.
// A search visits at most MAX_HOPS (48) capabilities; each hop costs a
// pointer read and an ID read through the single registered read port of
// the store.
// One request is worked on at a time; the next can be taken in the cycle
// after the previous result is loaded into the output register.
// The output register holds a result while the receiver stalls, and the
// next request is accepted meanwhile; its result waits until the slot frees.
// After reset the store is swept to zero, one dword per cycle;
// req.ready stays low during that sweep.

module pci_config_space_cap_walker_core
  import pcw_pkg::*;
#(
  parameter int CFG_BYTES = 256,
  parameter int MAX_HOPS  = 48
) (
  input  logic      clk,
  input  logic      rst,
  pcw_req_if.sink   req,
  pcw_rsp_if.source rsp
);

  pcw_cmd_t cmd;
  pcw_sts_t sts;

  // The sequencer decides the order of store accesses and when a result
  // is ready; the datapath holds the store, the walk registers and results.
  pcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcw_dp #(
    .CFG_BYTES (CFG_BYTES),
    .MAX_HOPS  (MAX_HOPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (req.func),
    .offset       (req.offset),
    .access_size  (req.access_size),
    .write_data   (req.write_data),
    .start_offset (req.start_offset),
    .cap_id       (req.cap_id),
    .match_any    (req.match_any),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .read_data    (rsp.read_data),
    .access_error (rsp.access_error),
    .cap_found    (rsp.cap_found),
    .cap_offset   (rsp.cap_offset)
  );

endmodule
